FILE: sv/irr_pkg.sv
// irr_pkg: shared codes and field widths for the ir ranger serial reader
// no dependencies; imported by ir_ranger_serial_reader_unit
package irr_pkg;

  // lines per sensor port and readings width
  localparam int LINE_W    = 4;
  localparam int RANGE_W   = 8;
  localparam int READ_W    = LINE_W * RANGE_W;
  localparam int BITPOS_W  = 3;

  // field widths
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 2;
  localparam int SETTLE_W  = 17;
  localparam int HALF_W    = 10;
  localparam int END_W     = 14;
  localparam int USE_W     = 3;
  localparam int TICK_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_GROUP  = 2'd1,
    KIND_SINGLE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE    = 2'd3;

  // register reset values
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 17'd70000;
  localparam logic [HALF_W-1:0]   HALF_RST   = 10'd100;
  localparam logic [END_W-1:0]    END_RST    = 14'd2000;
  localparam logic [USE_W-1:0]    USE_RST    = 3'd4;

endpackage

FILE: sv/ir_ranger_serial_reader_unit.sv
// ir_ranger_serial_reader_unit: bit-banged serial read of up to four ir range sensors
// depends on irr_pkg (codes, widths, register reset values)
//
//  channel | direction | handshake            | beat
//  in_     | input     | in_valid / in_ready   | kind, sensor index, sense lines
//  out_    | output    | out_valid / out_ready | drive lines, busy, done, readings, refused
//  cfg_    | input     | cfg_we                | register index and write data
//
// one beat in, one beat out; the sequencer state and the output register both load in the
// accept cycle, so a beat is taken every cycle as long as the output register is empty or
// drained in the same cycle.
// a stall on out_ready holds the output register and drops in_ready.
// rst_n is synchronous: idle sequencer, lines low, registers back to their defaults.
module ir_ranger_serial_reader_unit
  import irr_pkg::*;
#(
  parameter int NUM_SENSORS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [IDX_W-1:0]     in_sensor_index,
  input  logic [LINE_W-1:0]    in_sense_lines,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LINE_W-1:0]    out_drive_lines,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [READ_W-1:0]    out_readings,
  output logic                 out_start_refused,
  // configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  // sensors that can actually be wired to the four-line ports
  localparam int NumUsable = (NUM_SENSORS < LINE_W) ? NUM_SENSORS : LINE_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_HIGH,
    PH_LOW,
    PH_END
  } phase_t;

  // configuration registers
  logic [SETTLE_W-1:0] settle_ticks_r;
  logic [HALF_W-1:0]   half_ticks_r;
  logic [END_W-1:0]    end_ticks_r;
  logic [USE_W-1:0]    use_count_r;

  // sequencer state
  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_count_r, tick_count_nxt;
  logic [BITPOS_W-1:0] bit_pos_r, bit_pos_nxt;
  logic [LINE_W-1:0]   active_mask_r, active_mask_nxt;
  logic [LINE_W-1:0]   drive_level_r, drive_level_nxt;
  logic [READ_W-1:0]   acc_r, acc_nxt;

  // output register
  logic                out_valid_r;
  logic [LINE_W-1:0]   out_drive_r;
  logic                out_busy_r;
  logic                out_done_r, done_nxt;
  logic [READ_W-1:0]   out_readings_r, readings_nxt;
  logic                out_refused_r, refused_nxt;

  logic                in_fire;
  logic [TICK_W-1:0]   tick_inc;
  logic [TICK_W-1:0]   settle_lim, half_lim, end_lim;
  logic [LINE_W-1:0]   group_mask, single_mask;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RST;
      half_ticks_r   <= HALF_RST;
      end_ticks_r    <= END_RST;
      use_count_r    <= USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETTLE: settle_ticks_r <= cfg_wdata;
        REG_HALF:   half_ticks_r   <= cfg_wdata[HALF_W-1:0];
        REG_END:    end_ticks_r    <= cfg_wdata[END_W-1:0];
        REG_USE:    use_count_r    <= cfg_wdata[USE_W-1:0];
        default:    ;
      endcase
    end
  end

  // interval limits, a zero length counts as one tick
  assign settle_lim = (settle_ticks_r == '0) ? TICK_W'(1) : settle_ticks_r;
  assign half_lim   = (half_ticks_r == '0)   ? TICK_W'(1) : TICK_W'(half_ticks_r);
  assign end_lim    = (end_ticks_r == '0)    ? TICK_W'(1) : TICK_W'(end_ticks_r);
  assign tick_inc   = tick_count_r + TICK_W'(1);

  // sensor masks for the two start kinds
  always_comb begin
    for (int i = 0; i < LINE_W; i++) begin
      group_mask[i]  = (i < NumUsable) && (int'(use_count_r) > i);
      single_mask[i] = (int'(in_sensor_index) < NumUsable) && (int'(in_sensor_index) == i);
    end
  end

  // sequencer next state
  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    bit_pos_nxt     = bit_pos_r;
    active_mask_nxt = active_mask_r;
    drive_level_nxt = drive_level_r;
    acc_nxt         = acc_r;
    done_nxt        = 1'b0;
    refused_nxt     = 1'b0;
    readings_nxt    = '0;
    unique case (kind_t'(in_kind))
      KIND_GROUP, KIND_SINGLE: begin
        if (phase_r != PH_IDLE) begin
          refused_nxt = 1'b1;
        end else begin
          active_mask_nxt = (kind_t'(in_kind) == KIND_GROUP) ? group_mask : single_mask;
          phase_nxt       = PH_SETTLE;
          tick_count_nxt  = '0;
          bit_pos_nxt     = BITPOS_W'(7);
          acc_nxt         = '0;
          drive_level_nxt = '0;
        end
      end
      KIND_TICK: begin
        if (phase_r != PH_IDLE) begin
          tick_count_nxt = tick_inc;
        end
        unique case (phase_r)
          PH_SETTLE: begin
            if (tick_inc >= settle_lim) begin
              phase_nxt       = PH_HIGH;
              tick_count_nxt  = '0;
              drive_level_nxt = active_mask_r;
            end
          end
          PH_HIGH: begin
            if (tick_inc >= half_lim) begin
              phase_nxt       = PH_LOW;
              tick_count_nxt  = '0;
              drive_level_nxt = '0;
            end
          end
          PH_LOW: begin
            if (tick_inc >= half_lim) begin
              // sample one bit of every active sensor, msb first
              for (int i = 0; i < LINE_W; i++) begin
                if (active_mask_r[i] && in_sense_lines[i]) begin
                  acc_nxt[RANGE_W*i + int'(bit_pos_r)] = 1'b1;
                end
              end
              tick_count_nxt  = '0;
              drive_level_nxt = active_mask_r;
              if (bit_pos_r == '0) begin
                phase_nxt = PH_END;
              end else begin
                bit_pos_nxt = bit_pos_r - BITPOS_W'(1);
                phase_nxt   = PH_HIGH;
              end
            end
          end
          PH_END: begin
            if (tick_inc >= end_lim) begin
              phase_nxt       = PH_IDLE;
              tick_count_nxt  = '0;
              drive_level_nxt = '0;
              bit_pos_nxt     = BITPOS_W'(7);
              done_nxt        = 1'b1;
              readings_nxt    = acc_r;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      bit_pos_r     <= BITPOS_W'(7);
      active_mask_r <= '0;
      drive_level_r <= '0;
      acc_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r        <= phase_nxt;
        tick_count_r   <= tick_count_nxt;
        bit_pos_r      <= bit_pos_nxt;
        active_mask_r  <= active_mask_nxt;
        drive_level_r  <= drive_level_nxt;
        acc_r          <= acc_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_drive_r    <= drive_level_nxt;
      out_busy_r     <= (phase_nxt != PH_IDLE);
      out_done_r     <= done_nxt;
      out_readings_r <= readings_nxt;
      out_refused_r  <= refused_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_lines   = out_drive_r;
  assign out_busy_res      = out_busy_r;
  assign out_done_res      = out_done_r;
  assign out_readings      = out_readings_r;
  assign out_start_refused = out_refused_r;

  // a finished sequence is never still busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r)
    else $error("done reported while still busy");

  // readings only show on the finishing beat
  a_readings_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |-> out_readings_r == '0)
    else $error("readings nonzero without done");

  // a refused start only happens while busy
  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_refused_r |-> out_busy_r && !out_done_r)
    else $error("start refused while idle");

  // only selected sensors are ever driven
  a_drive_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (drive_level_r & ~active_mask_r) == '0)
    else $error("clock line driven outside active mask");

  // the line is low whenever the sequencer is idle
  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> drive_level_r == '0)
    else $error("clock line high while idle");

endmodule
